/* design/unreachable_node_tracker_defines.svh */
// Assertion macros shared by the tracker RTL.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef UNREACHABLE_NODE_TRACKER_DEFINES_SVH
`define UNREACHABLE_NODE_TRACKER_DEFINES_SVH

// Check that is masked while reset is held.
`define UNT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define UNT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/unt_pkg.sv */
// Shared types and constants for the unreachable node tracker.
// No dependencies; used by unt_cell, unt_scan and the top level.
package unt_pkg;

  localparam int KEY_W  = 256;
  localparam int TIME_W = 32;

  localparam logic [TIME_W-1:0] GRACE_RESET = 32'd7200;  // 120 minutes

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_MARK   = 2'd2,
    OP_NEXT   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INSERT,
    WR_TOUCH,
    WR_REMOVE,
    WR_MARK
  } wr_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] fail_since;
    logic [TIME_W-1:0] probed_at;
    logic              reported;
  } entry_t;

  // Broadcast to every cell: rotate the ring or apply one indexed write.
  typedef struct packed {
    logic              shift;
    wr_op_t            op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } cell_cmd_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic              match_hit;
    logic              match_rep;
    logic [TIME_W-1:0] match_ff;
    logic              free_hit;
    logic              best_hit;
    logic [KEY_W-1:0]  best_key;
  } scan_res_t;

endpackage

/* design/unt_cell.sv */
// One table slot of the tracker ring: holds an entry, rotates it to the next
// cell during a scan and takes indexed writes. Depends on unt_pkg.
module unt_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  unt_pkg::cell_cmd_t   cmd,
  input  logic [IDX_W-1:0]     wr_idx,
  input  unt_pkg::entry_t      nbr,
  output unt_pkg::entry_t      ent
);

  logic                         valid_r, valid_nxt;
  logic [unt_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [unt_pkg::TIME_W-1:0]   ff_r, ff_nxt;
  logic [unt_pkg::TIME_W-1:0]   lt_r, lt_nxt;
  logic                         rep_r, rep_nxt;
  logic                         sel;

  assign sel = (wr_idx == IDX_W'(CELL_IDX));

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    ff_nxt    = ff_r;
    lt_nxt    = lt_r;
    rep_nxt   = rep_r;
    if (cmd.shift) begin
      valid_nxt = nbr.valid;
      key_nxt   = nbr.key;
      ff_nxt    = nbr.fail_since;
      lt_nxt    = nbr.probed_at;
      rep_nxt   = nbr.reported;
    end else if (sel) begin
      unique case (cmd.op)
        unt_pkg::WR_INSERT: begin
          valid_nxt = 1'b1;
          key_nxt   = cmd.key;
          ff_nxt    = cmd.now;
          lt_nxt    = cmd.now;
          rep_nxt   = 1'b0;
        end
        unt_pkg::WR_TOUCH:  lt_nxt    = cmd.now;
        unt_pkg::WR_REMOVE: valid_nxt = 1'b0;
        unt_pkg::WR_MARK:   rep_nxt   = 1'b1;
        unt_pkg::WR_NONE:   ;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    ff_r  <= ff_nxt;
    lt_r  <= lt_nxt;
    rep_r <= rep_nxt;
  end

  assign ent.valid      = valid_r;
  assign ent.key        = key_r;
  assign ent.fail_since = ff_r;
  assign ent.probed_at  = lt_r;
  assign ent.reported   = rep_r;

endmodule

/* design/unt_scan.sv */
// Scan unit at the head of the ring: looks at one slot per cycle and keeps
// the key match, the lowest free slot and the oldest entry. Depends on unt_pkg.
module unt_scan #(
  parameter int IDX_W = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  unt_pkg::scan_ctl_t          ctl,
  input  logic [IDX_W-1:0]            idx,
  input  unt_pkg::entry_t             head,
  input  logic [unt_pkg::KEY_W-1:0]   req_key,
  output unt_pkg::scan_res_t          res,
  output logic [IDX_W-1:0]            match_idx,
  output logic [IDX_W-1:0]            free_idx
);

  logic                         match_hit_r, match_hit_nxt;
  logic                         free_hit_r, free_hit_nxt;
  logic                         best_hit_r, best_hit_nxt;
  logic [IDX_W-1:0]             match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]             free_idx_r, free_idx_nxt;
  logic                         match_rep_r, match_rep_nxt;
  logic [unt_pkg::TIME_W-1:0]   match_ff_r, match_ff_nxt;
  logic [unt_pkg::TIME_W-1:0]   best_time_r, best_time_nxt;
  logic [unt_pkg::KEY_W-1:0]    best_key_r, best_key_nxt;
  logic                         hit, older;

  assign hit   = head.valid && (head.key == req_key);
  assign older = head.valid && (!best_hit_r || (head.probed_at < best_time_r));

  always_comb begin
    match_hit_nxt = match_hit_r;
    free_hit_nxt  = free_hit_r;
    best_hit_nxt  = best_hit_r;
    match_idx_nxt = match_idx_r;
    free_idx_nxt  = free_idx_r;
    match_rep_nxt = match_rep_r;
    match_ff_nxt  = match_ff_r;
    best_time_nxt = best_time_r;
    best_key_nxt  = best_key_r;
    if (ctl.clear) begin
      match_hit_nxt = 1'b0;
      free_hit_nxt  = 1'b0;
      best_hit_nxt  = 1'b0;
    end else if (ctl.step) begin
      // keep the first hit and the first hole; strict compare keeps the lowest slot
      if (hit && !match_hit_r) begin
        match_hit_nxt = 1'b1;
        match_idx_nxt = idx;
        match_rep_nxt = head.reported;
        match_ff_nxt  = head.fail_since;
      end
      if (!head.valid && !free_hit_r) begin
        free_hit_nxt = 1'b1;
        free_idx_nxt = idx;
      end
      if (older) begin
        best_hit_nxt  = 1'b1;
        best_time_nxt = head.probed_at;
        best_key_nxt  = head.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_hit_r <= 1'b0;
      free_hit_r  <= 1'b0;
      best_hit_r  <= 1'b0;
    end else begin
      match_hit_r <= match_hit_nxt;
      free_hit_r  <= free_hit_nxt;
      best_hit_r  <= best_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    match_rep_r <= match_rep_nxt;
    match_ff_r  <= match_ff_nxt;
    best_time_r <= best_time_nxt;
    best_key_r  <= best_key_nxt;
  end

  assign res.match_hit = match_hit_r;
  assign res.match_rep = match_rep_r;
  assign res.match_ff  = match_ff_r;
  assign res.free_hit  = free_hit_r;
  assign res.best_hit  = best_hit_r;
  assign res.best_key  = best_key_r;
  assign match_idx     = match_idx_r;
  assign free_idx      = free_idx_r;

endmodule

/* design/unreachable_node_tracker.sv */
// Unreachable node tracker: a ring of TABLE_DEPTH slot cells rotated past one scan unit.
// Each word makes one full ring rotation in the scan state, then one write in the act state;
// the result strobe is registered from the act state, and busy is high from scan through act.
// The receiver cannot stall; a new word may start in the cycle the result shows.
// Synchronous reset clears all slot valid bits and loads grace_r with 7200.
// Depends on unt_pkg, unt_cell, unt_scan and unreachable_node_tracker_defines.svh.
`include "unreachable_node_tracker_defines.svh"

module unreachable_node_tracker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_key_word_0,
  input  logic [63:0] in_key_word_1,
  input  logic [63:0] in_key_word_2,
  input  logic [63:0] in_key_word_3,
  input  logic [31:0] in_now_seconds,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_report_due,
  output logic        out_entry_removed,
  output logic        out_table_full,
  output logic        out_next_found,
  output logic [63:0] out_next_word_0,
  output logic [63:0] out_next_word_1,
  output logic [63:0] out_next_word_2,
  output logic [63:0] out_next_word_3
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  unt_pkg::state_t              state_r, state_nxt;
  logic [IDX_W-1:0]             cnt_r, cnt_nxt;
  logic [unt_pkg::TIME_W-1:0]   grace_r;
  unt_pkg::op_t                 op_r;
  logic [unt_pkg::KEY_W-1:0]    key_r;
  logic [unt_pkg::TIME_W-1:0]   now_r;
  logic                         accept;

  logic                         out_valid_r, out_valid_nxt;
  logic                         report_r, report_nxt;
  logic                         removed_r, removed_nxt;
  logic                         full_r, full_nxt;
  logic                         found_r, found_nxt;
  logic [unt_pkg::KEY_W-1:0]    next_key_r, next_key_nxt;

  unt_pkg::cell_cmd_t           cmd;
  logic [IDX_W-1:0]             wr_idx;
  unt_pkg::entry_t              ents [TABLE_DEPTH];
  unt_pkg::scan_ctl_t           sctl;
  unt_pkg::scan_res_t           sres;
  logic [IDX_W-1:0]             match_idx, free_idx;
  logic [unt_pkg::TIME_W-1:0]   elapsed;

  assign accept = start && (state_r == unt_pkg::ST_IDLE);
  assign busy   = (state_r != unt_pkg::ST_IDLE);

  // ring: each cell takes its upper neighbor, slot 0 sits at the scan head
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    unt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .wr_idx (wr_idx),
      .nbr    (ents[(i + 1) % TABLE_DEPTH]),
      .ent    (ents[i])
    );
  end

  unt_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .idx       (cnt_r),
    .head      (ents[0]),
    .req_key   (key_r),
    .res       (sres),
    .match_idx (match_idx),
    .free_idx  (free_idx)
  );

  assign elapsed = now_r - sres.match_ff;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sctl.clear    = accept;
    sctl.step     = 1'b0;
    cmd.shift     = 1'b0;
    cmd.op        = unt_pkg::WR_NONE;
    cmd.key       = key_r;
    cmd.now       = now_r;
    wr_idx        = match_idx;
    out_valid_nxt = 1'b0;
    report_nxt    = 1'b0;
    removed_nxt   = 1'b0;
    full_nxt      = 1'b0;
    found_nxt     = 1'b0;
    next_key_nxt  = '0;
    unique case (state_r)
      unt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = unt_pkg::ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      unt_pkg::ST_SCAN: begin
        sctl.step = 1'b1;
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = unt_pkg::ST_ACT;
        end
      end
      unt_pkg::ST_ACT: begin
        state_nxt     = unt_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        unique case (op_r)
          unt_pkg::OP_RECORD: begin
            if (sres.match_hit) begin
              cmd.op     = unt_pkg::WR_TOUCH;
              report_nxt = !sres.match_rep && (elapsed > grace_r);
            end else if (sres.free_hit) begin
              cmd.op = unt_pkg::WR_INSERT;
              wr_idx = free_idx;
            end else begin
              full_nxt = 1'b1;
            end
          end
          unt_pkg::OP_EXPIRE: begin
            if (sres.match_hit) begin
              cmd.op      = unt_pkg::WR_REMOVE;
              removed_nxt = 1'b1;
            end
          end
          unt_pkg::OP_MARK: begin
            if (sres.match_hit) begin
              cmd.op = unt_pkg::WR_MARK;
            end
          end
          unt_pkg::OP_NEXT: begin
            found_nxt    = sres.best_hit;
            next_key_nxt = sres.best_hit ? sres.best_key : '0;
          end
          default: ;
        endcase
      end
      default: state_nxt = unt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= unt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      grace_r     <= unt_pkg::GRACE_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        grace_r <= cfg_wdata;
      end
    end
  end

  // hold the request word for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= unt_pkg::op_t'(in_opcode);
      key_r <= {in_key_word_3, in_key_word_2, in_key_word_1, in_key_word_0};
      now_r <= in_now_seconds;
    end
    report_r   <= report_nxt;
    removed_r  <= removed_nxt;
    full_r     <= full_nxt;
    found_r    <= found_nxt;
    next_key_r <= next_key_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_report_due    = report_r;
  assign out_entry_removed = removed_r;
  assign out_table_full    = full_r;
  assign out_next_found    = found_r;
  assign out_next_word_0   = next_key_r[63:0];
  assign out_next_word_1   = next_key_r[127:64];
  assign out_next_word_2   = next_key_r[191:128];
  assign out_next_word_3   = next_key_r[255:192];

  `UNT_ASSERT(a_strobe_after_act, out_valid_r |-> $past(state_r == unt_pkg::ST_ACT), "result strobe without write cycle")
  `UNT_ASSERT(a_full_rotation, (state_r == unt_pkg::ST_ACT) |-> ($past(state_r == unt_pkg::ST_SCAN) && $past(cnt_r == LAST_IDX)), "write cycle before ring came full circle")
  `UNT_ASSERT(a_one_flag, out_valid_r |-> $onehot0({report_r, removed_r, full_r, found_r}), "more than one result flag set")
  `UNT_ASSERT(a_full_on_record, (out_valid_r && full_r) |-> (op_r == unt_pkg::OP_RECORD), "table full flagged on a non-record word")
  `UNT_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |=> (state_r == unt_pkg::ST_IDLE && !out_valid_r), "reset did not return control to idle")

endmodule
